FILE: rtl/core/rpcb_pkg.sv
// ----------------------------------------------------------------------------
// rpcb_pkg
// Types, codes and sizes shared by the raw pixel channel and black lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcb_pkg;

    localparam int CFA_CELLS     = 16;
    localparam int BLACK_ENTRIES = 64;
    localparam int MAX_PLANES    = 4;
    localparam int COORD_BITS    = 16;

    localparam int COORD_W = 16;
    localparam logic [COORD_W-1:0] COORD_MASK =
        (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    localparam int CFA_AW = (CFA_CELLS > 1) ? $clog2(CFA_CELLS) : 1;
    localparam int BLK_AW = (BLACK_ENTRIES > 1) ? $clog2(BLACK_ENTRIES) : 1;

    // pattern cell (8 bits) times planes (3 bits) plus plane
    localparam int TAB_W = 11;

    localparam int DIVD_W     = COORD_W;
    localparam int REM_W      = 4;
    localparam int MOD_STAGES = 4;
    localparam int MOD_STEP   = DIVD_W / MOD_STAGES;

    typedef enum logic [1:0] {
        ACT_QUERY  = 2'd0,
        ACT_CFA_WR = 2'd1,
        ACT_BLK_WR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_CFA    = 2'd0,
        KIND_MONO   = 2'd1,
        KIND_LINEAR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_SENSOR_EXTENT = 3'd0,
        CFG_ACTIVE_ORIGIN = 3'd1,
        CFG_ACTIVE_SIZE   = 3'd2,
        CFG_IMAGE_KIND    = 3'd3,
        CFG_SAMPLES       = 3'd4,
        CFG_CHANNELS      = 3'd5,
        CFG_CFA_SHAPE     = 3'd6,
        CFG_BLACK_SHAPE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_action     action;
        logic [1:0]  plane;
        logic [5:0]  tidx;
        logic [23:0] tval;
        logic        hit;
        logic        fix_vld;
        logic [3:0]  fix_ch;
        logic        cfa_use;
        logic        blk_zero;
        logic        blk_use;
    } t_info;

endpackage

`default_nettype wire

FILE: rtl/core/rpcb_ram.sv
// ----------------------------------------------------------------------------
// rpcb_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/rpcb_mod_pipe.sv
// ----------------------------------------------------------------------------
// rpcb_mod_pipe
// Pipelined remainder of a coordinate by a small pattern size, a few
// restoring steps per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcb_mod_pipe (
    input  logic                       i_clk,
    input  logic [rpcb_pkg::DIVD_W-1:0] i_dividend,
    input  logic [rpcb_pkg::REM_W-1:0]  i_divisor,
    output logic [rpcb_pkg::REM_W-1:0]  o_rem
);
    import rpcb_pkg::*;

    logic [REM_W-1:0]  s_rem  [MOD_STAGES+1];
    logic [DIVD_W-1:0] s_word [MOD_STAGES+1];
    logic [REM_W-1:0]  n_rem  [MOD_STAGES];
    logic [DIVD_W-1:0] n_word [MOD_STAGES];
    logic [REM_W-1:0]  r_rem  [MOD_STAGES];
    logic [DIVD_W-1:0] r_word [MOD_STAGES];

    assign s_rem[0]  = '0;
    assign s_word[0] = i_dividend;

    for (genvar k = 0; k < MOD_STAGES; k++) begin : g_stage
        always_comb begin
            logic [REM_W:0]    acc;
            logic [REM_W-1:0]  rem;
            logic [DIVD_W-1:0] word;
            rem  = s_rem[k];
            word = s_word[k];
            acc  = '0;
            for (int j = 0; j < MOD_STEP; j++) begin
                acc  = {rem, word[DIVD_W-1]};
                word = {word[DIVD_W-2:0], 1'b0};
                if (acc >= {1'b0, i_divisor}) begin
                    acc = acc - {1'b0, i_divisor};
                end
                rem = acc[REM_W-1:0];
            end
            n_rem[k]  = rem;
            n_word[k] = word;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem[k];
            r_word[k] <= n_word[k];
        end

        assign s_rem[k+1]  = r_rem[k];
        assign s_word[k+1] = r_word[k];
    end

    assign o_rem = s_rem[MOD_STAGES];

endmodule

`default_nettype wire

FILE: rtl/core/raw_pixel_channel_black_lookup.sv
// ----------------------------------------------------------------------------
// raw_pixel_channel_black_lookup
// Per-sample color channel and black level lookup for raw sensor data.
// ----------------------------------------------------------------------------
// One word is taken in every cycle (busy stays low) and each word gives one
// result strobe on o_valid, in order; the receiver cannot stall. A word
// passes the capture and area-check stages, the staged remainder units that
// wrap the active-area offsets by the pattern sizes, the two multiply stages
// of the table address and the registered read of the table RAMs. Table
// loads travel the same pipeline and write at the read stage, so a query
// sees every load accepted before it. Both tables hold no reset value: load
// every entry that a query can reach before issuing queries. Configuration
// must be written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_pixel_channel_black_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [1:0]  i_plane,
    input  logic [5:0]  i_table_index,
    input  logic [23:0] i_table_value,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_channel_valid,
    output logic [3:0]  o_channel,
    output logic        o_black_valid,
    output logic [23:0] o_black_level
);
    import rpcb_pkg::*;

    logic [31:0] r_cfg_extent;
    logic [31:0] r_cfg_origin;
    logic [31:0] r_cfg_asize;
    logic [1:0]  r_cfg_kind;
    logic [2:0]  r_cfg_spp;
    logic [3:0]  r_cfg_ccc;
    logic [8:0]  r_cfg_cshape;
    logic [8:0]  r_cfg_bshape;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_extent <= '0;
            r_cfg_origin <= '0;
            r_cfg_asize  <= '0;
            r_cfg_kind   <= '0;
            r_cfg_spp    <= 3'd1;
            r_cfg_ccc    <= '0;
            r_cfg_cshape <= '0;
            r_cfg_bshape <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SENSOR_EXTENT: r_cfg_extent <= i_cfg_data;
                CFG_ACTIVE_ORIGIN: r_cfg_origin <= i_cfg_data;
                CFG_ACTIVE_SIZE:   r_cfg_asize  <= i_cfg_data;
                CFG_IMAGE_KIND:    r_cfg_kind   <= i_cfg_data[1:0];
                CFG_SAMPLES:       r_cfg_spp    <= i_cfg_data[2:0];
                CFG_CHANNELS:      r_cfg_ccc    <= i_cfg_data[3:0];
                CFG_CFA_SHAPE:     r_cfg_cshape <= i_cfg_data[8:0];
                CFG_BLACK_SHAPE:   r_cfg_bshape <= i_cfg_data[8:0];
            endcase
        end
    end

    logic [3:0] cfa_cols, cfa_rows, blk_cols, blk_rows;
    assign cfa_cols = r_cfg_cshape[3:0];
    assign cfa_rows = r_cfg_cshape[7:4];
    assign blk_cols = r_cfg_bshape[3:0];
    assign blk_rows = r_cfg_bshape[7:4];

    assign busy = 1'b0;

    // ---- stage A: capture word
    logic          r_a_vld;
    t_action       r_a_action;
    logic [15:0]   r_a_x, r_a_y;
    logic [1:0]    r_a_plane;
    logic [5:0]    r_a_tidx;
    logic [23:0]   r_a_tval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_action <= t_action'(i_action);
        r_a_x      <= i_pos_x;
        r_a_y      <= i_pos_y;
        r_a_plane  <= i_plane;
        r_a_tidx   <= i_table_index;
        r_a_tval   <= i_table_value;
    end

    // ---- stage B: area checks, offsets, kind decode
    logic [15:0] x, y, ew, eh, ox, oy, aw, ah, dx, dy;
    logic        full_area, in_area, hit;
    t_info       n_b_info;

    always_comb begin
        x         = r_a_x & COORD_MASK;
        y         = r_a_y & COORD_MASK;
        ew        = r_cfg_extent[15:0];
        eh        = r_cfg_extent[31:16];
        full_area = (r_cfg_asize == '0);
        ox        = full_area ? 16'd0 : r_cfg_origin[15:0];
        oy        = full_area ? 16'd0 : r_cfg_origin[31:16];
        aw        = full_area ? ew : r_cfg_asize[15:0];
        ah        = full_area ? eh : r_cfg_asize[31:16];
        dx        = x - ox;
        dy        = y - oy;
        in_area   = (x < ew) && (y < eh)
                 && ({1'b0, r_a_plane} < r_cfg_spp)
                 && (5'(r_a_plane) < 5'(MAX_PLANES))
                 && (aw != '0) && (ah != '0)
                 && (x >= ox) && (y >= oy) && (dx < aw) && (dy < ah);
        hit       = (r_a_action == ACT_QUERY) && in_area;

        n_b_info          = '0;
        n_b_info.action   = r_a_action;
        n_b_info.plane    = r_a_plane;
        n_b_info.tidx     = r_a_tidx;
        n_b_info.tval     = r_a_tval;
        n_b_info.hit      = hit;
        unique case (r_cfg_kind)
            KIND_CFA: begin
                n_b_info.cfa_use = hit && (r_a_plane == '0) && r_cfg_cshape[8]
                                && (cfa_cols != '0) && (cfa_rows != '0);
            end
            KIND_MONO: begin
                n_b_info.fix_vld = hit && (r_a_plane == '0) && (r_cfg_ccc != '0);
            end
            KIND_LINEAR: begin
                n_b_info.fix_vld = hit && ({2'b00, r_a_plane} < r_cfg_ccc);
                n_b_info.fix_ch  = {2'b00, r_a_plane};
            end
            default: begin
                n_b_info.fix_vld = 1'b0;
            end
        endcase
        n_b_info.blk_zero = hit && !r_cfg_bshape[8];
        n_b_info.blk_use  = hit && r_cfg_bshape[8] && (blk_cols != '0) && (blk_rows != '0);
    end

    logic        r_b_vld;
    t_info       r_b_info;
    logic [15:0] r_b_dx, r_b_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_info <= n_b_info;
        r_b_dx   <= dx;
        r_b_dy   <= dy;
    end

    // ---- stages M: wrap offsets by pattern sizes
    logic [REM_W-1:0] cfa_rx, cfa_ry, blk_rx, blk_ry;

    rpcb_mod_pipe u_mod_cx (.i_clk(i_clk), .i_dividend(r_b_dx), .i_divisor(cfa_cols),
                            .o_rem(cfa_rx));
    rpcb_mod_pipe u_mod_cy (.i_clk(i_clk), .i_dividend(r_b_dy), .i_divisor(cfa_rows),
                            .o_rem(cfa_ry));
    rpcb_mod_pipe u_mod_bx (.i_clk(i_clk), .i_dividend(r_b_dx), .i_divisor(blk_cols),
                            .o_rem(blk_rx));
    rpcb_mod_pipe u_mod_by (.i_clk(i_clk), .i_dividend(r_b_dy), .i_divisor(blk_rows),
                            .o_rem(blk_ry));

    logic  r_m_vld  [MOD_STAGES];
    t_info r_m_info [MOD_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOD_STAGES; k++) begin
                r_m_vld[k] <= 1'b0;
            end
        end else begin
            r_m_vld[0] <= r_b_vld;
            for (int k = 1; k < MOD_STAGES; k++) begin
                r_m_vld[k] <= r_m_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_info[0] <= r_b_info;
        for (int k = 1; k < MOD_STAGES; k++) begin
            r_m_info[k] <= r_m_info[k-1];
        end
    end

    // ---- stage D: row times columns plus column
    logic       r_d_vld;
    t_info      r_d_info;
    logic [7:0] r_d_cell, r_d_bcell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_m_vld[MOD_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_info  <= r_m_info[MOD_STAGES-1];
        r_d_cell  <= 8'(cfa_ry) * 8'(cfa_cols) + 8'(cfa_rx);
        r_d_bcell <= 8'(blk_ry) * 8'(blk_cols) + 8'(blk_rx);
    end

    // ---- stage E: black entry index, range checks
    logic [TAB_W-1:0] e_idx, c_idx;
    t_info            n_e_info;

    always_comb begin
        c_idx    = TAB_W'(r_d_cell);
        e_idx    = TAB_W'(r_d_bcell) * TAB_W'(r_cfg_spp) + TAB_W'(r_d_info.plane);
        n_e_info = r_d_info;
        n_e_info.cfa_use = r_d_info.cfa_use && (c_idx < TAB_W'(CFA_CELLS));
        n_e_info.blk_use = r_d_info.blk_use && (e_idx < TAB_W'(BLACK_ENTRIES));
    end

    logic             r_e_vld;
    t_info            r_e_info;
    logic [TAB_W-1:0] r_e_cidx, r_e_bidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_info <= n_e_info;
        r_e_cidx <= c_idx;
        r_e_bidx <= e_idx;
    end

    // ---- table access: loads write here, queries read here
    logic [TAB_W-1:0]  tidx_ext;
    logic              cfa_we, blk_we;
    logic [CFA_AW-1:0] cfa_addr;
    logic [BLK_AW-1:0] blk_addr;
    logic [3:0]        cfa_rdata;
    logic [23:0]       blk_rdata;

    always_comb begin
        tidx_ext = TAB_W'(r_e_info.tidx);
        cfa_we   = r_e_vld && (r_e_info.action == ACT_CFA_WR)
                && (tidx_ext < TAB_W'(CFA_CELLS));
        blk_we   = r_e_vld && (r_e_info.action == ACT_BLK_WR)
                && (tidx_ext < TAB_W'(BLACK_ENTRIES));
        cfa_addr = cfa_we ? tidx_ext[CFA_AW-1:0] : r_e_cidx[CFA_AW-1:0];
        blk_addr = blk_we ? tidx_ext[BLK_AW-1:0] : r_e_bidx[BLK_AW-1:0];
    end

    rpcb_ram #(.WIDTH(4), .DEPTH(CFA_CELLS)) u_cfa_ram (
        .i_clk   (i_clk),
        .i_we    (cfa_we),
        .i_addr  (cfa_addr),
        .i_wdata (r_e_info.tval[3:0]),
        .o_rdata (cfa_rdata)
    );

    rpcb_ram #(.WIDTH(24), .DEPTH(BLACK_ENTRIES)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_addr  (blk_addr),
        .i_wdata (r_e_info.tval),
        .o_rdata (blk_rdata)
    );

    // ---- stage F: table data ready
    logic  r_f_vld;
    t_info r_f_info;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_info <= r_e_info;
    end

    // ---- stage O: result register
    logic        n_ch_vld, n_bl_vld;
    logic [3:0]  n_ch;
    logic [23:0] n_bl;

    always_comb begin
        n_ch_vld = 1'b0;
        n_ch     = '0;
        if (r_f_info.fix_vld) begin
            n_ch_vld = 1'b1;
            n_ch     = r_f_info.fix_ch;
        end else if (r_f_info.cfa_use && (cfa_rdata < r_cfg_ccc)) begin
            n_ch_vld = 1'b1;
            n_ch     = cfa_rdata;
        end
        n_bl_vld = r_f_info.blk_zero || r_f_info.blk_use;
        n_bl     = r_f_info.blk_use ? blk_rdata : 24'd0;
    end

    logic        r_o_vld, r_o_ch_vld, r_o_bl_vld;
    logic [3:0]  r_o_ch;
    logic [23:0] r_o_bl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_ch_vld <= n_ch_vld;
        r_o_ch     <= n_ch;
        r_o_bl_vld <= n_bl_vld;
        r_o_bl     <= n_bl;
    end

    assign o_valid         = r_o_vld;
    assign o_channel_valid = r_o_ch_vld;
    assign o_channel       = r_o_ch;
    assign o_black_valid   = r_o_bl_vld;
    assign o_black_level   = r_o_bl;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the raw pixel channel and black-level lookup.
// A queue of words feeds a clocked driver. Each accepted word is run through
// a local model of the lookup tables and the active-area geometry. A clocked
// monitor checks every result strobe against the oldest expected lookup.
// The run steps through several register setups: reset values, CFA, mono,
// linear raw, unknown kind, empty and extreme areas, then random setups.
// ----------------------------------------------------------------------------

module tb;
    import rpcb_pkg::*;

    localparam logic [1:0] ACT_NONE  = 2'd3;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int STALL_LIMIT       = 2000;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  plane;
        logic [5:0]  tidx;
        logic [23:0] tval;
        logic        drain_first;
    } pixel_word_t;

    typedef struct packed {
        logic        ch_vld;
        logic [3:0]  ch;
        logic        bl_vld;
        logic [23:0] bl;
    } lookup_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = '0;
    logic [15:0] i_pos_x = '0;
    logic [15:0] i_pos_y = '0;
    logic [1:0]  i_plane = '0;
    logic [5:0]  i_table_index = '0;
    logic [23:0] i_table_value = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic        o_channel_valid;
    logic [3:0]  o_channel;
    logic        o_black_valid;
    logic [23:0] o_black_level;

    raw_pixel_channel_black_lookup i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_plane         (i_plane),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_channel_valid (o_channel_valid),
        .o_channel       (o_channel),
        .o_black_valid   (o_black_valid),
        .o_black_level   (o_black_level)
    );

    // register shadows, reset values
    logic [31:0] sh_extent = '0;
    logic [31:0] sh_origin = '0;
    logic [31:0] sh_size   = '0;
    logic [1:0]  sh_kind   = '0;
    logic [2:0]  sh_spp    = 3'd1;
    logic [3:0]  sh_chans  = '0;
    logic [8:0]  sh_cfa    = '0;
    logic [8:0]  sh_black  = '0;

    logic [3:0]  cfa_chan_tab [CFA_CELLS];
    logic [23:0] black_tab    [BLACK_ENTRIES];

    pixel_word_t word_q[$];
    lookup_t     lookup_q[$];
    int          idle_pct = 0;
    int          n_err = 0;
    int          stall_cnt = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic lookup_t lookup_pixel(input pixel_word_t w);
        lookup_t     r;
        int unsigned ew, eh, ox, oy, aw, ah, dx, dy, cc, cr, bc, br, cfa_idx, ent;
        logic        in_area;
        r = '0;
        case (w.action)
            ACT_CFA_WR: begin
                if (w.tidx < CFA_CELLS) cfa_chan_tab[w.tidx] = w.tval[3:0];
            end
            ACT_BLK_WR: begin
                if (w.tidx < BLACK_ENTRIES) black_tab[w.tidx] = w.tval;
            end
            ACT_QUERY: begin
                ew = sh_extent[15:0];
                eh = sh_extent[31:16];
                if (sh_size == '0) begin
                    ox = 0; oy = 0; aw = ew; ah = eh;
                end else begin
                    ox = sh_origin[15:0]; oy = sh_origin[31:16];
                    aw = sh_size[15:0];   ah = sh_size[31:16];
                end
                in_area = w.x < ew && w.y < eh && w.plane < sh_spp && w.plane < MAX_PLANES
                    && aw != 0 && ah != 0 && w.x >= ox && w.y >= oy
                    && (w.x - ox) < aw && (w.y - oy) < ah;
                if (in_area) begin
                    dx = w.x - ox;
                    dy = w.y - oy;
                    case (sh_kind)
                        KIND_CFA: begin
                            cc = sh_cfa[3:0];
                            cr = sh_cfa[7:4];
                            if (w.plane == 0 && sh_cfa[8] && cc != 0 && cr != 0) begin
                                cfa_idx = (dy % cr) * cc + (dx % cc);
                                if (cfa_idx < CFA_CELLS && cfa_chan_tab[cfa_idx] < sh_chans) begin
                                    r.ch_vld = 1'b1;
                                    r.ch     = cfa_chan_tab[cfa_idx];
                                end
                            end
                        end
                        KIND_MONO: begin
                            if (w.plane == 0 && sh_chans != 0) r.ch_vld = 1'b1;
                        end
                        KIND_LINEAR: begin
                            if (w.plane < sh_chans) begin
                                r.ch_vld = 1'b1;
                                r.ch     = 4'(w.plane);
                            end
                        end
                        default: ;
                    endcase
                    if (!sh_black[8]) begin
                        r.bl_vld = 1'b1;
                    end else begin
                        bc = sh_black[3:0];
                        br = sh_black[7:4];
                        if (bc != 0 && br != 0) begin
                            ent = ((dy % br) * bc + (dx % bc)) * sh_spp + w.plane;
                            if (ent < BLACK_ENTRIES) begin
                                r.bl_vld = 1'b1;
                                r.bl     = black_tab[ent];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        pixel_word_t nxt;
        logic        go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                lookup_q.insert(lookup_q.size(), lookup_pixel(word_q[0]));
                void'(word_q.pop_front());
            end
            if (!(start && busy)) begin
                go = 1'b0;
                if (word_q.size() != 0) begin
                    nxt = word_q[0];
                    go  = $urandom_range(0, 99) >= idle_pct
                        && !(nxt.drain_first && lookup_q.size() != 0);
                end
                start <= go;
                if (go) begin
                    i_action      <= nxt.action;
                    i_pos_x       <= nxt.x;
                    i_pos_y       <= nxt.y;
                    i_plane       <= nxt.plane;
                    i_table_index <= nxt.tidx;
                    i_table_value <= nxt.tval;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("[%0t] %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
            n_err++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        lookup_t e;
        if (i_rst_n && o_valid) begin
            if (lookup_q.size() == 0) begin
                $display("[%0t] unexpected result: expected none actual %0h %0h %0h %0h",
                         $time, o_channel_valid, o_channel, o_black_valid, o_black_level);
                n_err++;
            end else begin
                e = lookup_q.pop_front();
                check_field("channel_valid", e.ch_vld, o_channel_valid);
                check_field("channel", e.ch, o_channel);
                check_field("black_valid", e.bl_vld, o_black_valid);
                check_field("black_level", e.bl, o_black_level);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid
            || (word_q.size() == 0 && lookup_q.size() == 0)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no progress", $time);
            $display("tb: FAIL");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic push_word(input logic [1:0] act, input logic [15:0] x, input logic [15:0] y,
                             input logic [1:0] pl, input logic [5:0] ti, input logic [23:0] tv,
                             input logic drain = 1'b0);
        pixel_word_t w;
        w = '{action: act, x: x, y: y, plane: pl, tidx: ti, tval: tv, drain_first: drain};
        word_q.insert(word_q.size(), w);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || lookup_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_SENSOR_EXTENT: sh_extent = v;
            CFG_ACTIVE_ORIGIN: sh_origin = v;
            CFG_ACTIVE_SIZE:   sh_size   = v;
            CFG_IMAGE_KIND:    sh_kind   = v[1:0];
            CFG_SAMPLES:       sh_spp    = v[2:0];
            CFG_CHANNELS:      sh_chans  = v[3:0];
            CFG_CFA_SHAPE:     sh_cfa    = v[8:0];
            CFG_BLACK_SHAPE:   sh_black  = v[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setup(input logic [31:0] ext, input logic [31:0] org,
                               input logic [31:0] sz, input logic [1:0] kind,
                               input logic [2:0] spp, input logic [3:0] chans,
                               input logic [8:0] cfa, input logic [8:0] blk);
        wait_idle();
        write_reg(CFG_SENSOR_EXTENT, ext);
        write_reg(CFG_ACTIVE_ORIGIN, org);
        write_reg(CFG_ACTIVE_SIZE, sz);
        write_reg(CFG_IMAGE_KIND, 32'(kind));
        write_reg(CFG_SAMPLES, 32'(spp));
        write_reg(CFG_CHANNELS, 32'(chans));
        write_reg(CFG_CFA_SHAPE, 32'(cfa));
        write_reg(CFG_BLACK_SHAPE, 32'(blk));
    endtask

    function automatic logic [8:0] rand_shape();
        if ($urandom_range(0, 9) == 0) return 9'($urandom());
        return {1'($urandom_range(0, 9) != 0), 4'($urandom_range(0, 4)),
                4'($urandom_range(0, 4))};
    endfunction

    task automatic rand_setup();
        logic [15:0] w, h;
        logic [31:0] org, sz;
        logic [1:0]  kind;
        logic [2:0]  spp;
        w = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 80));
        h = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 80));
        org = {16'($urandom_range(0, 20)), 16'($urandom_range(0, 20))};
        sz  = ($urandom_range(0, 9) < 4) ? 32'd0
            : {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))};
        kind = ($urandom_range(0, 9) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
        spp  = ($urandom_range(0, 9) < 3) ? 3'($urandom_range(0, 7))
             : 3'($urandom_range(1, 4));
        apply_setup({h, w}, org, sz, kind, spp, 4'($urandom_range(0, 15)),
                    rand_shape(), rand_shape());
    endtask

    task automatic gen_random(input int n);
        int unsigned ew, eh, ox, oy, aw, ah, r, sel;
        logic [15:0] x, y;
        logic [1:0]  pl;
        for (int i = 0; i < n; i++) begin
            ew = sh_extent[15:0];
            eh = sh_extent[31:16];
            if (sh_size == '0) begin
                ox = 0; oy = 0; aw = ew; ah = eh;
            end else begin
                ox = sh_origin[15:0]; oy = sh_origin[31:16];
                aw = sh_size[15:0];   ah = sh_size[31:16];
            end
            sel = $urandom_range(0, 9);
            if (sel < 7 && aw != 0 && ah != 0) begin
                x = 16'(ox + $urandom_range(0, aw - 1));
                y = 16'(oy + $urandom_range(0, ah - 1));
            end else if (sel < 8) begin
                case ($urandom_range(0, 3))
                    0: begin x = 16'(ox - 1); y = 16'(oy - 1); end
                    1: begin x = 16'(ox + aw); y = 16'(oy + ah - 1); end
                    2: begin x = 16'(ew - 1); y = 16'(eh); end
                    default: begin x = 16'(ew); y = 16'(eh - 1); end
                endcase
            end else begin
                x = 16'($urandom());
                y = 16'($urandom());
            end
            if (sh_spp >= 1 && sh_spp <= 4 && $urandom_range(0, 9) < 8)
                pl = 2'($urandom_range(0, sh_spp - 1));
            else
                pl = 2'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 8)
                push_word(ACT_CFA_WR, x, y, pl,
                          ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 15)),
                          24'($urandom()));
            else if (r < 16)
                push_word(ACT_BLK_WR, x, y, pl, 6'($urandom()), 24'($urandom()));
            else if (r < 19)
                push_word(ACT_NONE, x, y, pl, 6'($urandom()), 24'($urandom()));
            else
                push_word(ACT_QUERY, x, y, pl, 6'($urandom()), 24'($urandom()),
                          i == n / 2);
        end
    endtask

    initial begin
        int phase;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load every table entry, then query with reset register values
        for (int i = 0; i < CFA_CELLS; i++)
            push_word(ACT_CFA_WR, '0, '0, '0, 6'(i), 24'($urandom()));
        for (int i = 0; i < BLACK_ENTRIES; i++)
            push_word(ACT_BLK_WR, '0, '0, '0, 6'(i), 24'($urandom()));
        gen_random(30);

        // 2x2 CFA over a 64x48 sensor
        apply_setup(32'h0030_0040, 32'd0, 32'd0, KIND_CFA, 3'd1, 4'd3, 9'h122, 9'h122);
        push_word(ACT_QUERY, 16'd0, 16'd0, 2'd0, '0, '0);
        push_word(ACT_QUERY, 16'd63, 16'd47, 2'd0, 6'h3F, 24'hFFFFFF);
        push_word(ACT_QUERY, 16'd64, 16'd0, 2'd0, '0, '0);
        push_word(ACT_QUERY, 16'd0, 16'd48, 2'd0, '0, '0);
        push_word(ACT_QUERY, 16'hFFFF, 16'hFFFF, 2'd3, '0, '0);
        push_word(ACT_QUERY, 16'd1, 16'd1, 2'd1, '0, '0);
        push_word(ACT_CFA_WR, '0, '0, '0, 6'd3, 24'hFFFFFF);
        push_word(ACT_QUERY, 16'd1, 16'd1, 2'd0, '0, '0);
        push_word(ACT_CFA_WR, 16'hFFFF, 16'hFFFF, 2'd3, 6'd3, 24'd2);
        push_word(ACT_QUERY, 16'd1, 16'd1, 2'd0, '0, '0);
        push_word(ACT_CFA_WR, '0, '0, '0, 6'd63, 24'd0);
        push_word(ACT_CFA_WR, '0, '0, '0, 6'd16, 24'hF);
        push_word(ACT_BLK_WR, '0, '0, '0, 6'd63, 24'hFFFFFF);
        push_word(ACT_BLK_WR, '0, '0, '0, 6'd0, 24'd0);
        push_word(ACT_QUERY, 16'd0, 16'd0, 2'd0, '0, '0, 1'b1);
        push_word(ACT_NONE, 16'hFFFF, 16'hFFFF, 2'd3, 6'h3F, 24'hFFFFFF);
        push_word(ACT_QUERY, 16'd2, 16'd0, 2'd0, '0, '0);
        push_word(ACT_QUERY, 16'd3, 16'd2, 2'd0, '0, '0);
        gen_random(80);

        idle_pct = 72;
        apply_setup(32'h0040_0040, 32'h0002_0004, 32'h000A_0014, KIND_CFA, 3'd2, 4'd15,
                    9'h153, 9'h144);
        gen_random(90);

        idle_pct = 0;
        apply_setup(32'h0020_0030, 32'd0, 32'd0, KIND_MONO, 3'd4, 4'd1, 9'h022, 9'h000);
        gen_random(90);

        idle_pct = 27;
        apply_setup(32'h0018_0018, 32'h0001_0001, 32'h0010_0010, KIND_LINEAR, 3'd3, 4'd2,
                    9'h111, 9'h135);
        gen_random(90);

        idle_pct = 0;
        apply_setup(32'hFFFF_FFFF, 32'hFFF0_FFF0, 32'hFFFF_FFFF, KIND_NONE, 3'd7, 4'd15,
                    9'h1FF, 9'h1FF);
        gen_random(60);
        apply_setup(32'hFFFF_FFFF, 32'd0, 32'd0, KIND_CFA, 3'd1, 4'd15, 9'h0FF, 9'h1FF);
        gen_random(60);

        idle_pct = 72;
        apply_setup(32'h0010_0010, 32'h0001_0001, 32'h0005_0000, KIND_CFA, 3'd0, 4'd0,
                    9'h1F0, 9'h10F);
        gen_random(40);

        for (phase = 0; phase < 6; phase++) begin
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 72;
                2: idle_pct = 0;
                default: idle_pct = 27;
            endcase
            rand_setup();
            gen_random(70);
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (n_err == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/rpcb_pkg.sv
rtl/core/rpcb_ram.sv
rtl/core/rpcb_mod_pipe.sv
rtl/core/raw_pixel_channel_black_lookup.sv
dv/tb.sv
